@@ rtl/core/pnm_pkg.sv @@
package pnm_pkg;

   localparam int PALETTE_DEPTH = 255;
   localparam int VALUE_BITS    = 16;
   localparam int IDX_BITS      = $clog2(PALETTE_DEPTH + 1);
   localparam logic [VALUE_BITS-1:0] VAL_LIMIT = {VALUE_BITS{1'b1}};

   typedef enum logic [1:0] {
      CMD_BYTE    = 2'd0,
      CMD_EOF     = 2'd1,
      CMD_READ    = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_PIXEL  = 3'd0,
      KIND_HEADER = 3'd1,
      KIND_ENTRY  = 3'd2,
      KIND_END    = 3'd3,
      KIND_ERROR  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_MAGIC = 2'd1,
      ERR_FULL  = 2'd2,
      ERR_EARLY = 2'd3
   } err_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic [7:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  pixel_value;
      logic [2:0]  image_format;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [15:0] max_level;
      logic [15:0] entry_red;
      logic [15:0] entry_green;
      logic [15:0] entry_blue;
      logic [7:0]  colors_used;
      logic [1:0]  error_code;
      logic        last_of_run;
   } rsp_type;

   // Search control sent into the cell chain.
   typedef struct packed {
      logic        start;
      logic [47:0] key;
   } srch_type;

   // Search status back from the chain.
   typedef struct packed {
      logic                done;
      logic                hit;
      logic [IDX_BITS-1:0] index;
   } hit_type;

endpackage

@@ rtl/core/pnm_if.sv @@
interface pnm_req_if;
   logic                 valid;
   logic                 ready;
   pnm_pkg::req_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pnm_rsp_if;
   logic                 valid;
   logic                 ready;
   pnm_pkg::rsp_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/pnm_stream_palette_decoder.sv @@
// Header, control and bitmap words give their first result word in the
// cycle after acceptance; a palette lookup adds a search through the cell
// chain. Raw P4 bytes emit up to 8 words, one per cycle while the
// receiver is ready. Throughput: one input word per result sequence; new
// words wait until the last result word is taken. Reset is synchronous and
// clears all parser state; palette slots are valid only below the fill count.
module pnm_stream_palette_decoder (
   input logic     clock,
   input logic     reset,
   pnm_req_if.sink   req_ch,
   pnm_rsp_if.source rsp_ch
);
   import pnm_pkg::*;

   localparam logic [3:0] PH_MAGIC = 4'd0, PH_WIDTH = 4'd1, PH_HEIGHT = 4'd2,
      PH_MAXVAL = 4'd3, PH_PIXELS = 4'd4, PH_DONE = 4'd5, PH_HALT = 4'd6;

   typedef enum logic [2:0] {ST_IDLE, ST_EMIT, ST_WAIT, ST_BITS} st_type;

   st_type      st_ff;
   logic [3:0]  phase_ff;
   logic [2:0]  fmt_ff;
   logic [15:0] tok_ff;
   logic        tin_ff, tcom_ff, tmark_ff, tstop_ff;
   logic [15:0] w_ff, h_ff, mx_ff, col_ff;
   logic [31:0] pcnt_ff;
   logic [1:0]  comp_ff;
   logic [31:0] rg_ff;
   logic [IDX_BITS-1:0] pal_ff;
   // Queue of up to two pending result words plus a flag for pending lookup.
   logic [2:0]  k0_ff, k1_ff;
   logic [7:0]  p0_ff, p1_ff;
   logic [1:0]  e0_ff, e1_ff;
   logic [47:0] ent_ff;
   logic [1:0]  nq_ff;
   logic        look_ff, issue_ff;
   // An end of file that finished a pixel token reports after the lookup.
   logic        eof_ff;
   logic [47:0] lkey_ff;
   logic [7:0]  byte_ff;
   logic [3:0]  bit_ff, nbits_ff;
   logic        last_ff;

   srch_type    srch;
   hit_type     sres;
   logic [47:0] rd_entry;
   logic        wr_en;

   assign srch.start = issue_ff;
   assign srch.key   = lkey_ff;
   assign wr_en      = (st_ff == ST_WAIT) && sres.done && !sres.hit &&
                       (pal_ff < IDX_BITS'(PALETTE_DEPTH));

   pnm_chain u_chain (
      .clock, .reset, .srch, .fill_count (pal_ff), .wr_en,
      .wr_idx (pal_ff), .wr_key (lkey_ff), .rd_idx (req_ch.payload.entry_index),
      .rd_entry, .result (sres)
   );

   logic [31:0] total;
   assign total = 32'(w_ff) * 32'(h_ff);

   assign req_ch.ready = (st_ff == ST_IDLE);

   logic out_last;
   always_comb begin
      out_last = 1'b1;
      if (st_ff == ST_EMIT) out_last = (nq_ff == 2'd1) && !look_ff && !eof_ff;
      if (st_ff == ST_BITS) out_last = last_ff;
   end

   assign rsp_ch.valid = (st_ff == ST_EMIT) || (st_ff == ST_BITS);
   always_comb begin
      rsp_ch.payload = '0;
      rsp_ch.payload.kind         = (st_ff == ST_BITS) ? KIND_PIXEL : k0_ff;
      rsp_ch.payload.pixel_value  = (st_ff == ST_BITS) ?
                                    {7'd0, ~byte_ff[3'(4'd7 - bit_ff)]} : p0_ff;
      rsp_ch.payload.image_format = fmt_ff;
      rsp_ch.payload.image_width  = w_ff;
      rsp_ch.payload.image_height = h_ff;
      rsp_ch.payload.max_level    = mx_ff;
      if (st_ff == ST_EMIT && k0_ff == KIND_ENTRY) begin
         rsp_ch.payload.entry_red   = ent_ff[47:32];
         rsp_ch.payload.entry_green = ent_ff[31:16];
         rsp_ch.payload.entry_blue  = ent_ff[15:0];
      end
      rsp_ch.payload.colors_used  = 8'(pal_ff);
      rsp_ch.payload.error_code   = (st_ff == ST_BITS) ? ERR_NONE : e0_ff;
      rsp_ch.payload.last_of_run  = out_last;
   end

   // Combinational per-word update written as a sequential parse over
   // temporaries; at most one lookup and two direct results per word.
   logic [3:0]  ph;
   logic [2:0]  fm;
   logic [15:0] tk, wv, hv, mv;
   logic        ti, tc, tm, ts;
   logic [31:0] pc;
   logic [1:0]  cc;
   logic [31:0] rg;
   logic [2:0]  qk [2];
   logic [7:0]  qp [2];
   logic [1:0]  qe [2];
   logic [1:0]  qn;
   logic        lk;
   logic [47:0] lkey;
   logic [15:0] v;
   logic [19:0] acc;
   logic [7:0]  c;
   logic        sp, dig, first, bmp;

   always_comb begin
      ph = phase_ff; fm = fmt_ff; tk = tok_ff; wv = w_ff; hv = h_ff; mv = mx_ff;
      ti = tin_ff; tc = tcom_ff; tm = tmark_ff; ts = tstop_ff;
      pc = pcnt_ff; cc = comp_ff; rg = rg_ff;
      qk[0] = '0; qk[1] = '0; qp[0] = '0; qp[1] = '0; qe[0] = '0; qe[1] = '0;
      qn = '0; lk = 1'b0; lkey = '0; v = '0; acc = '0;
      c = req_ch.payload.data_byte;
      sp = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
      dig = (c >= 8'h30 && c <= 8'h39);
      first = !ti;
      bmp = (fm == 3'd1) || (fm == 3'd4);
      // Text handling for header and P2/P3 pixels, and end of file.
      begin : text
         logic do_text, fin, add;
         do_text = 1'b0; fin = 1'b0; add = 1'b0;
         if (req_ch.payload.command == CMD_BYTE) begin
            if (ph < PH_PIXELS || (ph == PH_PIXELS && (fm == 3'd2 || fm == 3'd3)))
               do_text = 1'b1;
         end
         if (do_text) begin
            if (tc) begin
               if (c == 8'h0a) begin
                  tc = 1'b0;
                  fin = ti;
               end
            end else if (c == 8'h23) begin
               tc = 1'b1;
            end else if (sp) begin
               fin = ti;
            end else begin
               add = 1'b1;
            end
         end
         if (req_ch.payload.command == CMD_EOF && ph != PH_HALT && ti &&
             (ph < PH_PIXELS || (ph == PH_PIXELS && (fm == 3'd2 || fm == 3'd3))))
            fin = 1'b1;
         if (add) begin
            ti = 1'b1;
            if (ph == PH_MAGIC) begin
               if (first) begin
                  fm = 3'd0;
                  if (c == 8'h50) tm = 1'b1;
                  tk = 16'd1;
               end else if (tk == 16'd1) begin
                  if (tm && c >= 8'h31 && c <= 8'h36) fm = c[2:0];
                  tk = 16'd2;
               end
            end else if (first && c == 8'h2d) begin
               tm = 1'b1;
            end else if (first && c == 8'h2b) begin
               tm = tm;
            end else if (dig && !ts) begin
               acc = 20'(tk) * 20'd10 + 20'(c - 8'h30);
               tk = (acc > 20'(VAL_LIMIT)) ? VAL_LIMIT : acc[15:0];
            end else begin
               ts = 1'b1;
            end
         end
         if (fin) begin
            v = tm ? 16'd0 : tk;
            bmp = (fm == 3'd1) || (fm == 3'd4);
            case (ph)
               PH_MAGIC: begin
                  if (fm != 3'd0) begin
                     ph = PH_WIDTH;
                     if (bmp) mv = 16'd1;
                  end else begin
                     qk[qn[0]] = KIND_ERROR; qe[qn[0]] = ERR_MAGIC; qn = qn + 2'd1;
                     ph = PH_HALT;
                  end
               end
               PH_WIDTH: begin wv = v; ph = PH_HEIGHT; end
               PH_HEIGHT: begin
                  hv = v;
                  if (bmp) begin
                     qk[qn[0]] = KIND_HEADER; qn = qn + 2'd1;
                     ph = (32'(wv) * 32'(hv) == 32'd0) ? PH_DONE : PH_PIXELS;
                  end else ph = PH_MAXVAL;
               end
               PH_MAXVAL: begin
                  mv = v;
                  qk[qn[0]] = KIND_HEADER; qn = qn + 2'd1;
                  ph = (32'(wv) * 32'(hv) == 32'd0) ? PH_DONE : PH_PIXELS;
               end
               PH_PIXELS: begin
                  if (fm == 3'd2) begin
                     lk = 1'b1; lkey = {v, v, v};
                  end else if (cc == 2'd0) begin
                     rg = {v, 16'd0}; cc = 2'd1;
                  end else if (cc == 2'd1) begin
                     rg = {rg[31:16], v}; cc = 2'd2;
                  end else begin
                     cc = 2'd0; lk = 1'b1; lkey = {rg, v};
                  end
               end
               default: ;
            endcase
            tk = '0; ti = 1'b0; tm = 1'b0; ts = 1'b0;
         end
         if (req_ch.payload.command == CMD_EOF && ph != PH_HALT && !lk) begin
            qk[qn[0]] = (ph == PH_DONE) ? KIND_END : KIND_ERROR;
            qe[qn[0]] = (ph == PH_DONE) ? ERR_NONE : ERR_EARLY;
            qn = qn + 2'd1;
            ph = PH_HALT;
         end
      end
      if (req_ch.payload.command == CMD_BYTE && ph == PH_PIXELS &&
          phase_ff == PH_PIXELS) begin
         case (fm)
            3'd1: begin
               if (c == 8'h31 || c == 8'h30) begin
                  qk[0] = KIND_PIXEL; qp[0] = {7'd0, c == 8'h30}; qn = 2'd1;
                  pc = pc + 32'd1;
                  if (pc >= total) ph = PH_DONE;
               end
            end
            3'd5: begin lk = 1'b1; lkey = {8'd0, c, 8'd0, c, 8'd0, c}; end
            3'd6: begin
               if (cc == 2'd0) begin rg = {8'd0, c, 16'd0}; cc = 2'd1; end
               else if (cc == 2'd1) begin rg = {rg[31:16], 8'd0, c}; cc = 2'd2; end
               else begin cc = 2'd0; lk = 1'b1; lkey = {rg, 8'd0, c}; end
            end
            default: ;
         endcase
      end
   end

   logic [15:0] remn;
   assign remn = w_ff - col_ff;

   always_ff @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready &&
                    req_ch.payload.command == CMD_RESTART)) begin
         st_ff <= ST_IDLE;
         phase_ff <= PH_MAGIC; fmt_ff <= '0; tok_ff <= '0;
         tin_ff <= 1'b0; tcom_ff <= 1'b0; tmark_ff <= 1'b0; tstop_ff <= 1'b0;
         w_ff <= '0; h_ff <= '0; mx_ff <= '0; col_ff <= '0; pcnt_ff <= '0;
         comp_ff <= '0; rg_ff <= '0; pal_ff <= '0;
         nq_ff <= '0; look_ff <= 1'b0; issue_ff <= 1'b0; eof_ff <= 1'b0;
      end else begin
         issue_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  if (req_ch.payload.command == CMD_READ) begin
                     k0_ff <= KIND_ENTRY; p0_ff <= '0; e0_ff <= ERR_NONE;
                     ent_ff <= (req_ch.payload.entry_index < 8'(pal_ff)) ? rd_entry : '0;
                     nq_ff <= 2'd1; look_ff <= 1'b0;
                     st_ff <= ST_EMIT;
                  end else if (req_ch.payload.command == CMD_BYTE &&
                               phase_ff == PH_PIXELS && fmt_ff == 3'd4) begin
                     byte_ff <= req_ch.payload.data_byte;
                     bit_ff <= '0;
                     nbits_ff <= (remn > 16'd8) ? 4'd8 : remn[3:0];
                     last_ff <= (remn == 16'd1) || (pcnt_ff + 32'd1 >= total);
                     st_ff <= ST_BITS;
                  end else begin
                     phase_ff <= ph; fmt_ff <= fm; tok_ff <= tk;
                     tin_ff <= ti; tcom_ff <= tc; tmark_ff <= tm; tstop_ff <= ts;
                     w_ff <= wv; h_ff <= hv; mx_ff <= mv; pcnt_ff <= pc;
                     comp_ff <= cc; rg_ff <= rg;
                     k0_ff <= qk[0]; p0_ff <= qp[0]; e0_ff <= qe[0];
                     k1_ff <= qk[1]; p1_ff <= qp[1]; e1_ff <= qe[1];
                     ent_ff <= '0;
                     nq_ff <= qn; look_ff <= lk; lkey_ff <= lkey;
                     eof_ff <= lk && (req_ch.payload.command == CMD_EOF);
                     if (qn != 2'd0) st_ff <= ST_EMIT;
                     else if (lk) begin issue_ff <= 1'b1; st_ff <= ST_WAIT; end
                  end
               end
            end
            ST_EMIT: begin
               if (rsp_ch.ready) begin
                  if (nq_ff == 2'd1 && eof_ff && !look_ff) begin
                     k0_ff <= (phase_ff == PH_DONE) ? KIND_END : KIND_ERROR;
                     p0_ff <= '0;
                     e0_ff <= (phase_ff == PH_DONE) ? ERR_NONE : ERR_EARLY;
                     eof_ff <= 1'b0;
                     phase_ff <= PH_HALT;
                  end else begin
                     k0_ff <= k1_ff; p0_ff <= p1_ff; e0_ff <= e1_ff;
                     nq_ff <= nq_ff - 2'd1;
                     if (nq_ff == 2'd1) begin
                        if (look_ff) begin
                           issue_ff <= 1'b1; st_ff <= ST_WAIT;
                        end else st_ff <= ST_IDLE;
                     end
                  end
               end
            end
            ST_WAIT: begin
               if (sres.done) begin
                  look_ff <= 1'b0;
                  pcnt_ff <= pcnt_ff + 32'd1;
                  if (pcnt_ff + 32'd1 >= total) phase_ff <= PH_DONE;
                  if (sres.hit) begin
                     k0_ff <= KIND_PIXEL; p0_ff <= 8'(sres.index); e0_ff <= ERR_NONE;
                     nq_ff <= 2'd1;
                  end else if (pal_ff >= IDX_BITS'(PALETTE_DEPTH)) begin
                     k0_ff <= KIND_ERROR; p0_ff <= '0; e0_ff <= ERR_FULL;
                     k1_ff <= KIND_PIXEL; p1_ff <= '0; e1_ff <= ERR_NONE;
                     nq_ff <= 2'd2;
                  end else begin
                     k0_ff <= KIND_PIXEL; p0_ff <= 8'(pal_ff); e0_ff <= ERR_NONE;
                     pal_ff <= pal_ff + IDX_BITS'(1);
                     nq_ff <= 2'd1;
                  end
                  st_ff <= ST_EMIT;
               end
            end
            ST_BITS: begin
               if (rsp_ch.ready) begin
                  pcnt_ff <= pcnt_ff + 32'd1;
                  if (col_ff + 16'd1 >= w_ff) col_ff <= '0;
                  else col_ff <= col_ff + 16'd1;
                  if (pcnt_ff + 32'd1 >= total) phase_ff <= PH_DONE;
                  if (last_ff) st_ff <= ST_IDLE;
                  else begin
                     bit_ff <= bit_ff + 4'd1;
                     last_ff <= (bit_ff + 4'd2 >= nbits_ff) ||
                                (pcnt_ff + 32'd2 >= total);
                  end
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

@@ rtl/core/pnm_cell.sv @@
// One palette slot. The probe key walks down the chain one cell per cycle,
// and a cell flags a match if it holds a filled entry equal to the key.
module pnm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          probe_vld,
   input  logic [47:0]                   probe_key,
   input  logic                          probe_hit,
   input  logic [pnm_pkg::IDX_BITS-1:0]  probe_idx,
   input  logic [pnm_pkg::IDX_BITS-1:0]  my_idx,
   input  logic [pnm_pkg::IDX_BITS-1:0]  fill_count,
   input  logic                          wr_en,
   input  logic [47:0]                   wr_key,
   output logic [47:0]                   entry,
   output logic                          next_vld,
   output logic [47:0]                   next_key,
   output logic                          next_hit,
   output logic [pnm_pkg::IDX_BITS-1:0]  next_idx
);
   import pnm_pkg::*;

   logic [47:0] entry_ff;
   logic        vld_ff, hit_ff;
   logic [47:0] key_ff;
   logic [IDX_BITS-1:0] idx_ff;
   logic        match;

   assign match = !probe_hit && (my_idx < fill_count) && (entry_ff == probe_key);

   always_ff @(posedge clock) begin
      if (wr_en) entry_ff <= wr_key;
      key_ff <= probe_key;
      hit_ff <= probe_hit || match;
      idx_ff <= match ? my_idx : probe_idx;
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= probe_vld;
   end

   assign entry    = entry_ff;
   assign next_vld = vld_ff;
   assign next_key = key_ff;
   assign next_hit = hit_ff;
   assign next_idx = idx_ff;
endmodule

@@ rtl/core/pnm_chain.sv @@
// Row of palette cells. A search ripples through every cell in turn; the
// first matching slot wins.
module pnm_chain (
   input  logic                          clock,
   input  logic                          reset,
   input  pnm_pkg::srch_type             srch,
   input  logic [pnm_pkg::IDX_BITS-1:0]  fill_count,
   input  logic                          wr_en,
   input  logic [pnm_pkg::IDX_BITS-1:0]  wr_idx,
   input  logic [47:0]                   wr_key,
   input  logic [pnm_pkg::IDX_BITS-1:0]  rd_idx,
   output logic [47:0]                   rd_entry,
   output pnm_pkg::hit_type              result
);
   import pnm_pkg::*;

   logic                vld [PALETTE_DEPTH+1];
   logic [47:0]         key [PALETTE_DEPTH+1];
   logic                hit [PALETTE_DEPTH+1];
   logic [IDX_BITS-1:0] idx [PALETTE_DEPTH+1];
   logic [47:0]         ent [PALETTE_DEPTH];

   assign vld[0] = srch.start;
   assign key[0] = srch.key;
   assign hit[0] = 1'b0;
   assign idx[0] = '0;

   for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
      pnm_cell u_cell (
         .clock, .reset,
         .probe_vld (vld[i]), .probe_key (key[i]), .probe_hit (hit[i]),
         .probe_idx (idx[i]), .my_idx (IDX_BITS'(i)), .fill_count,
         .wr_en     (wr_en && wr_idx == IDX_BITS'(i)), .wr_key,
         .entry     (ent[i]),
         .next_vld  (vld[i+1]), .next_key (key[i+1]), .next_hit (hit[i+1]),
         .next_idx  (idx[i+1])
      );
   end

   always_comb begin
      rd_entry = '0;
      for (int j = 0; j < PALETTE_DEPTH; j++)
         if (rd_idx == IDX_BITS'(j)) rd_entry = ent[j];
   end

   assign result.done  = vld[PALETTE_DEPTH];
   assign result.hit   = hit[PALETTE_DEPTH];
   assign result.index = idx[PALETTE_DEPTH];
endmodule

@@ bench/pnm_tb_checker.sv @@
`timescale 1ns / 1ps

module pnm_tb_checker (
   input logic  clock,
   input logic  reset,
   pnm_req_if.sink  req_mon,
   pnm_rsp_if.sink  rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   import pnm_pkg::*;

   localparam logic [3:0] PH_MAGIC  = 4'd0;
   localparam logic [3:0] PH_WIDTH  = 4'd1;
   localparam logic [3:0] PH_HEIGHT = 4'd2;
   localparam logic [3:0] PH_MAXVAL = 4'd3;
   localparam logic [3:0] PH_PIXELS = 4'd4;
   localparam logic [3:0] PH_DONE   = 4'd5;
   localparam logic [3:0] PH_HALT   = 4'd6;

   logic [3:0]  phase;
   logic [2:0]  fmt;
   logic [15:0] tok_val;
   logic        tok_in, tok_comment, tok_neg, tok_stop;
   logic [15:0] width_q, height_q, maxval_q;
   logic [31:0] pix_count;
   logic [15:0] col_count;
   logic [1:0]  comp_count;
   logic [31:0] held_rg;
   logic [47:0] colors [PALETTE_DEPTH];
   logic [7:0]  color_count;

   rsp_type expected_words[$];

   assign pending_count = expected_words.size();

   function automatic bit is_bitmap();
      return fmt == 3'd1 || fmt == 3'd4;
   endfunction

   task automatic push_word(input kind_type k, input logic [7:0] pix, input err_type err,
                            input logic [47:0] rgb);
      rsp_type w;
      w.kind = k;
      w.pixel_value = pix;
      w.image_format = fmt;
      w.image_width = width_q;
      w.image_height = height_q;
      w.max_level = maxval_q;
      w.entry_red = rgb[47:32];
      w.entry_green = rgb[31:16];
      w.entry_blue = rgb[15:0];
      w.colors_used = color_count;
      w.error_code = err;
      w.last_of_run = 1'b0;
      expected_words.push_back(w);
   endtask

   task automatic give_pixel(input logic [7:0] pix);
      push_word(KIND_PIXEL, pix, ERR_NONE, 48'd0);
      pix_count++;
      if (pix_count >= {16'd0, width_q} * {16'd0, height_q}) phase = PH_DONE;
   endtask

   task automatic find_color(input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b);
      logic [47:0] key;
      key = {r, g, b};
      for (int i = 0; i < color_count; i++) begin
         if (colors[i] == key) begin
            give_pixel(i[7:0]);
            return;
         end
      end
      if (color_count >= PALETTE_DEPTH) begin
         push_word(KIND_ERROR, 8'd0, ERR_FULL, 48'd0);
         give_pixel(8'd0);
         return;
      end
      colors[color_count] = key;
      color_count++;
      give_pixel(color_count - 8'd1);
   endtask

   task automatic header_complete();
      phase = PH_PIXELS;
      push_word(KIND_HEADER, 8'd0, ERR_NONE, 48'd0);
      if (width_q == 0 || height_q == 0) phase = PH_DONE;
   endtask

   task automatic close_token();
      logic [15:0] v;
      v = tok_neg ? 16'd0 : tok_val;
      case (phase)
         PH_MAGIC: begin
            if (fmt != 0) begin
               phase = PH_WIDTH;
               if (is_bitmap()) maxval_q = 16'd1;
            end else begin
               push_word(KIND_ERROR, 8'd0, ERR_MAGIC, 48'd0);
               phase = PH_HALT;
            end
         end
         PH_WIDTH: begin
            width_q = v;
            phase = PH_HEIGHT;
         end
         PH_HEIGHT: begin
            height_q = v;
            if (is_bitmap()) header_complete();
            else phase = PH_MAXVAL;
         end
         PH_MAXVAL: begin
            maxval_q = v;
            header_complete();
         end
         PH_PIXELS: begin
            if (fmt == 3'd2) find_color(v, v, v);
            else if (comp_count == 0) begin
               held_rg = {v, 16'd0};
               comp_count = 1;
            end else if (comp_count == 1) begin
               held_rg[15:0] = v;
               comp_count = 2;
            end else begin
               comp_count = 0;
               find_color(held_rg[31:16], held_rg[15:0], v);
            end
         end
         default: ;
      endcase
      tok_val = 0;
      tok_in = 0;
      tok_neg = 0;
      tok_stop = 0;
   endtask

   task automatic token_char(input logic [7:0] c);
      logic first;
      logic [19:0] acc;
      first = !tok_in;
      tok_in = 1;
      if (phase == PH_MAGIC) begin
         if (first) begin
            fmt = 0;
            if (c == "P") tok_neg = 1;
            tok_val = 1;
         end else if (tok_val == 1) begin
            if (tok_neg && c >= "1" && c <= "6") fmt = 3'(c - "0");
            tok_val = 2;
         end
         return;
      end
      if (first && c == "-") begin
         tok_neg = 1;
         return;
      end
      if (first && c == "+") return;
      if (c >= "0" && c <= "9" && !tok_stop) begin
         acc = tok_val * 20'd10 + (c - "0");
         tok_val = (acc > 20'hFFFF) ? 16'hFFFF : acc[15:0];
      end else begin
         tok_stop = 1;
      end
   endtask

   task automatic text_char(input logic [7:0] c);
      logic blank;
      blank = c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
      if (tok_comment) begin
         if (c != 8'h0A) return;
         tok_comment = 0;
      end else if (c == "#") begin
         tok_comment = 1;
         return;
      end
      if (blank) begin
         if (tok_in) close_token();
      end else begin
         token_char(c);
      end
   endtask

   task automatic raw_bits(input logic [7:0] c);
      int n;
      n = width_q - col_count;
      if (n > 8) n = 8;
      for (int k = 0; k < n; k++) begin
         col_count++;
         if (col_count >= width_q) col_count = 0;
         give_pixel(c[7-k] ? 8'd0 : 8'd1);
         if (phase != PH_PIXELS) break;
      end
   endtask

   task automatic clear_image();
      phase = PH_MAGIC;
      fmt = 0;
      tok_val = 0;
      {tok_in, tok_comment, tok_neg, tok_stop} = 4'd0;
      width_q = 0;
      height_q = 0;
      maxval_q = 0;
      pix_count = 0;
      col_count = 0;
      comp_count = 0;
      held_rg = 0;
      color_count = 0;
   endtask

   task automatic decode_word(input req_type w);
      int first_new;
      logic [47:0] rgb;
      logic [15:0] b16;
      first_new = expected_words.size();
      b16 = {8'd0, w.data_byte};
      case (cmd_type'(w.command))
         CMD_BYTE: begin
            if (phase < PH_PIXELS) text_char(w.data_byte);
            else if (phase == PH_PIXELS) begin
               case (fmt)
                  3'd1: begin
                     if (w.data_byte == "1") give_pixel(8'd0);
                     else if (w.data_byte == "0") give_pixel(8'd1);
                  end
                  3'd2, 3'd3: text_char(w.data_byte);
                  3'd4: raw_bits(w.data_byte);
                  3'd5: find_color(b16, b16, b16);
                  default: begin
                     if (comp_count == 0) begin
                        held_rg = {b16, 16'd0};
                        comp_count = 1;
                     end else if (comp_count == 1) begin
                        held_rg[15:0] = b16;
                        comp_count = 2;
                     end else begin
                        comp_count = 0;
                        find_color(held_rg[31:16], held_rg[15:0], b16);
                     end
                  end
               endcase
            end
         end
         CMD_EOF: begin
            if (phase != PH_HALT) begin
               if (tok_in && (phase < PH_PIXELS ||
                   (phase == PH_PIXELS && (fmt == 3'd2 || fmt == 3'd3))))
                  close_token();
               if (phase != PH_HALT) begin
                  if (phase == PH_DONE) push_word(KIND_END, 8'd0, ERR_NONE, 48'd0);
                  else push_word(KIND_ERROR, 8'd0, ERR_EARLY, 48'd0);
                  phase = PH_HALT;
               end
            end
         end
         CMD_READ: begin
            rgb = (w.entry_index < color_count) ? colors[w.entry_index] : 48'd0;
            push_word(KIND_ENTRY, 8'd0, ERR_NONE, rgb);
         end
         default: clear_image();
      endcase
      if (expected_words.size() > first_new)
         expected_words[expected_words.size()-1].last_of_run = 1'b1;
   endtask

   task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic compare_word(input rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected result word, kind %0d", $realtime, got.kind);
         fail_count++;
         return;
      end
      want = expected_words.pop_front();
      if (got.kind != want.kind) report("kind", got.kind, want.kind);
      if (got.pixel_value != want.pixel_value)
         report("pixel_value", got.pixel_value, want.pixel_value);
      if (got.image_format != want.image_format)
         report("image_format", got.image_format, want.image_format);
      if (got.image_width != want.image_width)
         report("image_width", got.image_width, want.image_width);
      if (got.image_height != want.image_height)
         report("image_height", got.image_height, want.image_height);
      if (got.max_level != want.max_level) report("max_level", got.max_level, want.max_level);
      if (got.entry_red != want.entry_red) report("entry_red", got.entry_red, want.entry_red);
      if (got.entry_green != want.entry_green)
         report("entry_green", got.entry_green, want.entry_green);
      if (got.entry_blue != want.entry_blue) report("entry_blue", got.entry_blue, want.entry_blue);
      if (got.colors_used != want.colors_used)
         report("colors_used", got.colors_used, want.colors_used);
      if (got.error_code != want.error_code) report("error_code", got.error_code, want.error_code);
      if (got.last_of_run != want.last_of_run)
         report("last_of_run", got.last_of_run, want.last_of_run);
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         clear_image();
         expected_words.delete();
      end else begin
         // The result side is checked first; a word accepted at this edge can only
         // produce results on later edges.
         if (rsp_mon.valid && rsp_mon.ready) compare_word(rsp_mon.payload);
         if (req_mon.valid && req_mon.ready) decode_word(req_mon.payload);
      end
   end
endmodule

@@ bench/tb_pnm_stream_palette_decoder.sv @@
`timescale 1ns / 1ps

module tb_pnm_stream_palette_decoder;
   import pnm_pkg::*;

   localparam int CYCLE_LIMIT = 200_000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   cycle_count;
   logic long_hold;
   logic hold_done;

   pnm_req_if req_ch ();
   pnm_rsp_if rsp_ch ();

   pnm_stream_palette_decoder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   pnm_tb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch.sink),
      .rsp_mon       (rsp_ch.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_pnm_stream_palette_decoder NOT OK");
            $finish;
         end
      end
   end

   // The receiver stalls in a pattern of its own and once holds off for a long stretch.
   initial begin
      int mode;
      rsp_ch.ready <= 1'b0;
      mode = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_done = 1'b1;
         end
         if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   int burst_left;

   task automatic send_word(input cmd_type cmd, input logic [7:0] data, input logic [7:0] idx);
      req_type w;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      w.command = cmd;
      w.data_byte = data;
      w.entry_index = idx;
      req_ch.valid <= 1'b1;
      req_ch.payload <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(CMD_BYTE, s[i], 8'($urandom_range(0, 255)));
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic string rand_gap();
      string s;
      case ($urandom_range(0, 5))
         0: s = "\n";
         1: s = "\t";
         2: s = " # note\n";
         3: s = "\r\n";
         default: s = " ";
      endcase
      return s;
   endfunction

   // One small image with random content; mostly well formed, sometimes cut short.
   task automatic random_image();
      int f, w, h, total, mv;
      f = $urandom_range(1, 6);
      w = $urandom_range(0, 3);
      h = $urandom_range(0, 2);
      total = w * h;
      mv = $urandom_range(1, 3) == 1 ? 65535 : $urandom_range(1, 255);
      send_word(CMD_RESTART, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      send_text($sformatf("P%0d%s%0d%s%0d", f, rand_gap(), w, rand_gap(), h));
      if (f != 1 && f != 4) send_text($sformatf("%s%0d", rand_gap(), mv));
      send_text(rand_gap());
      if ($urandom_range(0, 7) == 0) total = total / 2;
      case (f)
         1: for (int i = 0; i < total; i++)
               send_text($urandom_range(0, 1) ? "1 " : "0");
         2: for (int i = 0; i < total; i++)
               send_text($sformatf("%0d%s", $urandom_range(0, 3), rand_gap()));
         3: for (int i = 0; i < total * 3; i++)
               send_text($sformatf("%0d ", $urandom_range(0, 2)));
         4: for (int i = 0; i < h * ((w + 7) / 8); i++)
               send_word(CMD_BYTE, 8'($urandom_range(0, 255)), 8'd0);
         5: for (int i = 0; i < total; i++)
               send_word(CMD_BYTE, 8'($urandom_range(0, 255)), 8'd0);
         default: for (int i = 0; i < total * 3; i++)
               send_word(CMD_BYTE, 8'($urandom_range(0, 3)), 8'd0);
      endcase
      if ($urandom_range(0, 3) == 0)
         send_word(CMD_READ, 8'd0, 8'($urandom_range(0, 7)));
      send_word(CMD_EOF, 8'($urandom_range(0, 255)), 8'd0);
      if ($urandom_range(0, 4) == 0) send_word(CMD_EOF, 8'd0, 8'd0);
   endtask

   initial begin
      long_hold = 1'b0;
      hold_done = 1'b0;
      burst_left = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: comments, signs, saturation; height -7 reads as 0: an empty image.
      send_text("P2 # c\n+3 -7 99999\n5 255 5 0 ");
      send_word(CMD_READ, 8'h00, 8'd0);
      send_word(CMD_READ, 8'h00, 8'd254);
      send_word(CMD_EOF, 8'hFF, 8'd255);
      drain();
      // Bad magic, then an end of file after the halt.
      send_word(CMD_RESTART, 8'h00, 8'd0);
      send_text("Q7 ");
      send_word(CMD_EOF, 8'h00, 8'd0);
      drain();
      // Raw bitmap with a row that does not end on a byte boundary.
      send_word(CMD_RESTART, 8'h00, 8'd0);
      send_text("P4 10 2\n");
      send_word(CMD_BYTE, 8'hA5, 8'd0);
      send_word(CMD_BYTE, 8'hC0, 8'd0);
      send_word(CMD_BYTE, 8'h5A, 8'd0);
      send_word(CMD_BYTE, 8'h3F, 8'd0);
      send_word(CMD_EOF, 8'h00, 8'd0);
      drain();

      // Long receiver hold while the sender keeps offering words.
      long_hold = 1'b1;
      send_word(CMD_RESTART, 8'h00, 8'd0);
      send_text("P1 3 2 101 010 ");
      send_word(CMD_EOF, 8'h00, 8'd0);
      drain();

      for (int n = 0; n < 3; n++) begin
         random_image();
         if ($urandom_range(0, 1) == 0) drain();
      end
      for (int n = 0; n < 4; n++)
         send_word(cmd_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 254)));
      drain();

      if (fail_count == 0) begin
         $display("tb_pnm_stream_palette_decoder OK");
      end else begin
         $display("tb_pnm_stream_palette_decoder NOT OK");
      end
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/pnm_pkg.sv
rtl/core/pnm_if.sv
rtl/core/pnm_cell.sv
rtl/core/pnm_chain.sv
rtl/core/pnm_stream_palette_decoder.sv
bench/pnm_tb_checker.sv
bench/tb_pnm_stream_palette_decoder.sv
